@@ design/lfu_pkg.sv @@
// lfu_pkg: shared types and constants for the lfu page replacement unit
// used by lfu_ctrl, lfu_dpath and the top level; no dependencies
package lfu_pkg;

  // default geometry
  localparam int FRAMES_DEF     = 4;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int STAMP_BITS_DEF = 32;

  // stream word widths
  localparam int IN_DATA_W  = 16;
  localparam int EVICT_W    = 16;
  localparam int FIDX_W     = 2;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lfu_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch request, issue first table read
    logic scan;    // evaluate one table entry
    logic update;  // write table entry and load result register
  } lfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // entry under evaluation is the last frame
    logic out_free;   // result register can take a new word
  } lfu_status_t;

endpackage

@@ design/lfu_ram.sv @@
// lfu_ram: generic single write port, single read port ram with registered read
// no dependencies
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lfu_ctrl.sv @@
// lfu_ctrl: request sequencer (idle, scan, update) for the lfu unit
// depends on lfu_pkg
module lfu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lfu_pkg::lfu_status_t status,
  output lfu_pkg::lfu_cmd_t    cmd
);

  import lfu_pkg::*;

  lfu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        // no word is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/lfu_dpath.sv @@
// lfu_dpath: frame table, scan registers, victim selection and result register
// depends on lfu_pkg and lfu_ram
module lfu_dpath #(
  parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int STAMP_BITS = lfu_pkg::STAMP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lfu_pkg::lfu_cmd_t                cmd,
  output lfu_pkg::lfu_status_t             status,
  input  logic [lfu_pkg::IN_DATA_W-1:0]    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lfu_pkg::OUT_DATA_W-1:0]   out_data
);

  import lfu_pkg::*;

  localparam int IDX_W   = $clog2(FRAMES);
  localparam int ENTRY_W = PAGE_BITS + COUNT_BITS + STAMP_BITS;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(FRAMES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  // request and scan registers
  logic [PAGE_BITS-1:0]  page;
  logic [STAMP_BITS-1:0] tick;
  logic [IDX_W-1:0]      idx;
  logic                  found;
  logic [IDX_W-1:0]      hit_slot;
  logic [COUNT_BITS-1:0] hit_count;
  logic                  free_found;
  logic [IDX_W-1:0]      free_slot;
  logic [IDX_W-1:0]      best_slot;
  logic [COUNT_BITS-1:0] best_count;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [PAGE_BITS-1:0]  best_page;
  logic [FRAMES-1:0]     valid;

  // table ram access
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;

  logic [PAGE_BITS-1:0]  e_page;
  logic [COUNT_BITS-1:0] e_count;
  logic [STAMP_BITS-1:0] e_stamp;
  logic                  e_valid;
  logic                  e_better;

  logic [COUNT_BITS-1:0] new_count;
  logic                  replaced;

  assign e_page  = rdata[PAGE_BITS-1:0];
  assign e_count = rdata[PAGE_BITS +: COUNT_BITS];
  assign e_stamp = rdata[PAGE_BITS+COUNT_BITS +: STAMP_BITS];
  assign e_valid = valid[idx];

  // strict compares keep the lowest slot on full ties
  assign e_better = (idx == '0) || (e_count < best_count) ||
                    ((e_count == best_count) && (e_stamp < best_stamp));

  assign status.scan_last = (idx == LAST_IDX);
  assign status.out_free  = !out_valid || out_ready;

  // frame 0 is read while the request is taken, then one frame ahead of idx
  always_comb begin
    if (cmd.accept || status.scan_last) begin
      raddr = '0;
    end else begin
      raddr = idx + 1'b1;
    end
  end

  assign replaced = !found && !free_found;

  always_comb begin
    if (found) begin
      waddr = hit_slot;
    end else if (free_found) begin
      waddr = free_slot;
    end else begin
      waddr = best_slot;
    end
  end

  always_comb begin
    if (!found) begin
      new_count = COUNT_BITS'(1);
    end else if (hit_count == COUNT_MAX) begin
      new_count = hit_count;
    end else begin
      new_count = hit_count + 1'b1;
    end
  end

  assign wdata = {tick, new_count, page};

  lfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick      <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept && (tick != STAMP_MAX)) begin
        tick <= tick + 1'b1;
      end
      if (cmd.update) begin
        valid[waddr] <= 1'b1;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page       <= PAGE_BITS'(in_data);
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end
    if (cmd.scan) begin
      if (e_valid && (e_page == page) && !found) begin
        found     <= 1'b1;
        hit_slot  <= idx;
        hit_count <= e_count;
      end
      if (!e_valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx;
      end
      if (e_better) begin
        best_slot  <= idx;
        best_count <= e_count;
        best_stamp <= e_stamp;
        best_page  <= e_page;
      end
      if (!status.scan_last) begin
        idx <= idx + 1'b1;
      end
    end
    if (cmd.update) begin
      out_data <= {{(OUT_DATA_W - EVICT_W - FIDX_W - 2){1'b0}},
                   (replaced ? EVICT_W'(best_page) : EVICT_W'(0)),
                   replaced,
                   FIDX_W'(waddr),
                   found};
    end
  end

endmodule

@@ design/lfu_page_replacement_unit.sv @@
// lfu_page_replacement_unit: top level of the lfu page replacement unit
// depends on lfu_pkg, lfu_ctrl, lfu_dpath and lfu_ram
//
//  channel    | dir | handshake                 | word
//  -----------+-----+---------------------------+------------------------------------
//  request    | in  | s_axis_tvalid/tready      | s_axis_tdata[15:0] page_number
//  result     | out | m_axis_tvalid/tready      | m_axis_tdata: hit, frame_index,
//             |     |                           |   replaced, evicted_page, zero pad
//
// each request takes the word and starts the table read, walks the table one
// frame at a time through its single read port, then writes the chosen frame
// back and loads the result register
// a finished result sits in its own register, so the next request is taken
// while that word waits on m_axis_tready; only a second result stalls the update
// reset (rst, synchronous) clears the frame valid bits and the time counter;
// no clearing pass, the table ram is read only behind its valid bits
//
// page replacement: hit refreshes count (saturating) and stamp, a miss fills
// the lowest free frame, else the least count frame is evicted, ties to the
// oldest stamp, then to the lowest frame
module lfu_page_replacement_unit #(
  parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int STAMP_BITS = lfu_pkg::STAMP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request word
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lfu_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] page_number
  // result word
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lfu_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [0] hit, [2:1] frame_index,
                                                         // [3] replaced,
                                                         // [19:4] evicted_page,
                                                         // [23:20] zero
);

  import lfu_pkg::*;

  // command and status between sequencer and datapath
  lfu_cmd_t    cmd;
  lfu_status_t status;

  // sequencer: idle, walk the table, update
  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // frame table, scan and victim registers, result register
  lfu_dpath #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
